// ===== design/ymd_pkg.sv =====
`default_nettype none
package ymd_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_CA = 8'h18;
  localparam logic [7:0] BYTE_ABORT_UPPER = 8'h41;
  localparam logic [7:0] BYTE_ABORT_LOWER = 8'h61;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [10:0] SHORT_LEN = 11'd128;
  localparam logic [10:0] LONG_LEN = 11'd1024;
  localparam logic [10:0] CANCEL_LEN = 11'd2;

  localparam logic [23:0] TIMEOUT_RESET = 24'd1000000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int unsigned CFG_AW = 3;
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [2:0] {
    ST_GOOD    = 3'd0,
    ST_EOT     = 3'd1,
    ST_CANCEL  = 3'd2,
    ST_ABORT   = 3'd3,
    ST_ERROR   = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CLS_SOH,
    CLS_STX,
    CLS_EOT,
    CLS_CA,
    CLS_ABORT,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    logic       timeout;
    cls_t       cls;
    logic [7:0] rx_byte;
  } qent_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] packet_number;
    logic [10:0] packet_length;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/ymd_if.sv =====
`default_nettype none
interface ymd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface ymd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [2:0]  status;
  logic [7:0]  packet_number;
  logic [10:0] packet_length;

  modport source (output valid, output kind, output data_byte, output status,
                  output packet_number, output packet_length, input ready);
  modport sink (input valid, input kind, input data_byte, input status,
                input packet_number, input packet_length, output ready);
endinterface
`default_nettype wire

// ===== design/ymd_front.sv =====
`default_nettype none
module ymd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ymd_in_if.sink             in_ch,
  input  wire logic [23:0]   timeout_ticks,
  input  wire logic          q_full,
  output ymd_pkg::qent_t     q_wdata,
  output logic               q_push
);

  logic [23:0] tick_count_r;
  logic [23:0] tick_count_nxt;
  logic [23:0] tick_inc;
  logic        accept;
  logic        hit;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign tick_inc = tick_count_r + 24'd1;
  assign hit = (tick_inc >= timeout_ticks) || (tick_inc == 24'd0);

  always_comb begin
    tick_count_nxt = tick_count_r;
    q_push = 1'b0;
    q_wdata.timeout = 1'b0;
    q_wdata.rx_byte = in_ch.rx_byte;
    case (in_ch.rx_byte)
      ymd_pkg::BYTE_SOH: q_wdata.cls = ymd_pkg::CLS_SOH;
      ymd_pkg::BYTE_STX: q_wdata.cls = ymd_pkg::CLS_STX;
      ymd_pkg::BYTE_EOT: q_wdata.cls = ymd_pkg::CLS_EOT;
      ymd_pkg::BYTE_CA: q_wdata.cls = ymd_pkg::CLS_CA;
      ymd_pkg::BYTE_ABORT_UPPER: q_wdata.cls = ymd_pkg::CLS_ABORT;
      ymd_pkg::BYTE_ABORT_LOWER: q_wdata.cls = ymd_pkg::CLS_ABORT;
      default: q_wdata.cls = ymd_pkg::CLS_OTHER;
    endcase
    if (accept) begin
      if (in_ch.op == ymd_pkg::OP_TICK) begin
        if (hit) begin
          tick_count_nxt = 24'd0;
          q_push = 1'b1;
          q_wdata.timeout = 1'b1;
        end else begin
          tick_count_nxt = tick_inc;
        end
      end else begin
        tick_count_nxt = 24'd0;
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= 24'd0;
    end else begin
      tick_count_r <= tick_count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ymd_queue.sv =====
`default_nettype none
module ymd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ymd_pkg::qent_t wdata,
  output logic                full,
  input  wire logic           pop,
  output logic                rvalid,
  output ymd_pkg::qent_t      rdata
);

  ymd_pkg::qent_t            mem_r [ymd_pkg::QDEPTH];
  logic [ymd_pkg::QAW-1:0]   wr_ptr_r;
  logic [ymd_pkg::QAW-1:0]   rd_ptr_r;
  logic [ymd_pkg::QAW:0]     cnt_r;
  logic                      do_push;
  logic                      do_pop;

  assign full = (cnt_r == ymd_pkg::QAW'(0) + (ymd_pkg::QAW+1)'(ymd_pkg::QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && rvalid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: cnt_r <= cnt_r + 1'b1;
        2'b01: cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ymd_back.sv =====
`default_nettype none
module ymd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire ymd_pkg::qent_t q_rdata,
  output logic                q_pop,
  ymd_out_if.source           out_ch
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CA2,
    PH_SEQ,
    PH_CSEQ,
    PH_DATA,
    PH_CRCH,
    PH_CRCL
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic            long_packet_r, long_packet_nxt;
  logic [7:0]      seq_number_r, seq_number_nxt;
  logic [7:0]      seq_complement_r, seq_complement_nxt;
  logic [10:0]     byte_count_r, byte_count_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crc_high_r, crc_high_nxt;
  logic            out_valid_r, out_valid_nxt;
  ymd_pkg::res_t   out_r, out_nxt;
  ymd_pkg::res_t   res;
  logic            res_valid;
  logic            go;
  logic [10:0]     len;
  logic [10:0]     count_inc;
  logic [7:0]      b;

  assign go = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = go;
  assign b = q_rdata.rx_byte;
  assign len = long_packet_r ? ymd_pkg::LONG_LEN : ymd_pkg::SHORT_LEN;
  assign count_inc = byte_count_r + 11'd1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = out_r.kind;
  assign out_ch.data_byte = out_r.data_byte;
  assign out_ch.status = out_r.status;
  assign out_ch.packet_number = out_r.packet_number;
  assign out_ch.packet_length = out_r.packet_length;

  always_comb begin
    phase_nxt = phase_r;
    long_packet_nxt = long_packet_r;
    seq_number_nxt = seq_number_r;
    seq_complement_nxt = seq_complement_r;
    byte_count_nxt = byte_count_r;
    crc_nxt = crc_r;
    crc_high_nxt = crc_high_r;
    res_valid = 1'b0;
    res = '0;
    res.kind = ymd_pkg::KIND_STATUS;
    if (go) begin
      if (q_rdata.timeout) begin
        res_valid = 1'b1;
        res.status = ymd_pkg::ST_TIMEOUT;
        phase_nxt = PH_IDLE;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            case (q_rdata.cls)
              ymd_pkg::CLS_SOH, ymd_pkg::CLS_STX: begin
                long_packet_nxt = (q_rdata.cls == ymd_pkg::CLS_STX);
                byte_count_nxt = 11'd0;
                crc_nxt = 16'd0;
                phase_nxt = PH_SEQ;
              end
              ymd_pkg::CLS_EOT: begin
                res_valid = 1'b1;
                res.status = ymd_pkg::ST_EOT;
              end
              ymd_pkg::CLS_CA: phase_nxt = PH_CA2;
              ymd_pkg::CLS_ABORT: begin
                res_valid = 1'b1;
                res.status = ymd_pkg::ST_ABORT;
              end
              default: begin
                res_valid = 1'b1;
                res.status = ymd_pkg::ST_ERROR;
              end
            endcase
          end
          PH_CA2: begin
            res_valid = 1'b1;
            phase_nxt = PH_IDLE;
            if (q_rdata.cls == ymd_pkg::CLS_CA) begin
              res.status = ymd_pkg::ST_CANCEL;
              res.packet_length = ymd_pkg::CANCEL_LEN;
            end else begin
              res.status = ymd_pkg::ST_ERROR;
            end
          end
          PH_SEQ: begin
            seq_number_nxt = b;
            phase_nxt = PH_CSEQ;
          end
          PH_CSEQ: begin
            seq_complement_nxt = b;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            crc_nxt = ymd_pkg::crc_byte(crc_r, b);
            byte_count_nxt = count_inc;
            if (count_inc >= len) begin
              phase_nxt = PH_CRCH;
            end
            res_valid = 1'b1;
            res.kind = ymd_pkg::KIND_DATA;
            res.data_byte = b;
          end
          PH_CRCH: begin
            crc_high_nxt = b;
            phase_nxt = PH_CRCL;
          end
          PH_CRCL: begin
            res_valid = 1'b1;
            phase_nxt = PH_IDLE;
            if ((seq_number_r != ~seq_complement_r) || ({crc_high_r, b} != crc_r)) begin
              res.status = ymd_pkg::ST_ERROR;
            end else begin
              res.status = ymd_pkg::ST_GOOD;
              res.packet_number = seq_number_r;
              res.packet_length = len;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (go && res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      long_packet_r <= 1'b0;
      seq_number_r <= 8'd0;
      seq_complement_r <= 8'd0;
      byte_count_r <= 11'd0;
      crc_r <= 16'd0;
      crc_high_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      long_packet_r <= long_packet_nxt;
      seq_number_r <= seq_number_nxt;
      seq_complement_r <= seq_complement_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r <= crc_nxt;
      crc_high_r <= crc_high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== design/ymodem_packet_deframer_core.sv =====
`default_nettype none
// ymodem receive deframer: each input beat is a received byte or a timer tick, and the
// block returns payload bytes as they arrive followed by one status beat per packet
// (good data, end of transmission, cancel, abort, error or timeout). one beat is taken
// per clock when the result side keeps up; the classifier and tick counter feed a
// four-entry queue, and the packet state machine with its byte-wide crc-16 update drains
// it at one entry per cycle into an output register, so a stalled result only holds back
// input once the queue fills. timeout_ticks sits at apb byte address 0.
module ymodem_packet_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ymd_in_if.sink           in_ch,
  ymd_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [ymd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [23:0]     timeout_ticks_r;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  ymd_pkg::qent_t  q_wdata;
  ymd_pkg::qent_t  q_rdata;
  logic            reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[ymd_pkg::CFG_AW-1];
  assign prdata = (reg_sel == ymd_pkg::REG_TIMEOUT) ? {8'd0, timeout_ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= ymd_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == ymd_pkg::REG_TIMEOUT) begin
      timeout_ticks_r <= pwdata[23:0];
    end
  end

  ymd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .timeout_ticks (timeout_ticks_r),
    .q_full        (q_full),
    .q_wdata       (q_wdata),
    .q_push        (q_push)
  );

  ymd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  ymd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
